// ===== src/itt_pkg.sv =====
// ----------------------------------------------------------------------------
// itt_pkg: shared types and codes of the ID translation table
// Opcodes, status codes, field widths, the search token that walks the
// cell chain and the write command broadcast to the cells.
// ----------------------------------------------------------------------------
package itt_pkg;

	localparam int OPCODE_W  = 2;
	localparam int REAL_W    = 16;
	localparam int VID_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int VID_OUT_W = 6;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;

	// real id reported by a failed lookup
	localparam logic [REAL_W-1:0] NO_REAL = 16'hFFFF;

	// search token, moves one cell per cycle
	typedef struct packed {
		logic                valid;
		logic [OPCODE_W-1:0] opcode;
		logic [REAL_W-1:0]   real_id;
		logic [VID_W-1:0]    virtual_id;
		logic                hit;        // matching real id seen
		logic                free_found; // free entry seen
		logic                rd_used;    // used bit of the addressed entry
		logic [REAL_W-1:0]   rd_real;    // real id of the addressed entry
	} tok_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [REAL_W-1:0] real_id;
	} wr_t;

endpackage

// ===== src/itt_req_if.sv =====
// ----------------------------------------------------------------------------
// itt_req_if: request channel
// Valid/ready channel carrying one table operation per item.
// ----------------------------------------------------------------------------
interface itt_req_if import itt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [REAL_W-1:0]   real_id;
	logic [VID_W-1:0]    virtual_id;

	modport source (output valid, opcode, real_id, virtual_id, input ready);
	modport sink   (input valid, opcode, real_id, virtual_id, output ready);
endinterface

// ===== src/itt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itt_rsp_if: response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface itt_rsp_if import itt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [VID_OUT_W-1:0] virtual_id_out;
	logic [REAL_W-1:0]    real_id_out;

	modport source (output valid, status, virtual_id_out, real_id_out, input ready);
	modport sink   (input valid, status, virtual_id_out, real_id_out, output ready);
endinterface

// ===== src/itt_cell.sv =====
// ----------------------------------------------------------------------------
// itt_cell: one table entry
// Holds the used bit and real id of one virtual id. Updates the passing
// search token with match, first-free and direct-read information and
// hands it to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module itt_cell import itt_pkg::*; #(
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_t             tok_i,
	input  logic [IDX_W-1:0] hit_idx_i,
	input  logic [IDX_W-1:0] free_idx_i,
	input  wr_t              wr_i,
	input  logic [IDX_W-1:0] wr_idx_i,
	output tok_t             tok_o,
	output logic [IDX_W-1:0] hit_idx_o,
	output logic [IDX_W-1:0] free_idx_o
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
	localparam logic [VID_W-1:0] MY_VID = VID_W'(CELL_IDX);

	logic              used_q;
	logic [REAL_W-1:0] real_q;
	tok_t              tok_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [IDX_W-1:0]  free_idx_q;

	tok_t              tok_d;
	logic [IDX_W-1:0]  hit_idx_d;
	logic [IDX_W-1:0]  free_idx_d;
	logic              wr_sel;

	assign wr_sel = (wr_idx_i == MY_IDX);

	// token update for this entry
	always_comb begin
		tok_d      = tok_i;
		hit_idx_d  = hit_idx_i;
		free_idx_d = free_idx_i;
		if (tok_i.valid) begin
			if (!tok_i.hit && used_q && (real_q == tok_i.real_id)) begin
				tok_d.hit = 1'b1;
				hit_idx_d = MY_IDX;
			end
			if (!tok_i.free_found && !used_q) begin
				tok_d.free_found = 1'b1;
				free_idx_d       = MY_IDX;
			end
			if (tok_i.virtual_id == MY_VID) begin
				tok_d.rd_used = used_q;
				tok_d.rd_real = real_q;
			end
		end
	end

	// used bit and token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr_i.set && wr_sel) begin
				used_q <= 1'b1;
			end else if (wr_i.clr && wr_sel) begin
				used_q <= 1'b0;
			end
		end
	end

	// payload: stored real id and token indices
	always_ff @(posedge clk) begin
		hit_idx_q  <= hit_idx_d;
		free_idx_q <= free_idx_d;
		if (wr_i.set && wr_sel) begin
			real_q <= wr_i.real_id;
		end
	end

	assign tok_o      = tok_q;
	assign hit_idx_o  = hit_idx_q;
	assign free_idx_o = free_idx_q;

endmodule

// ===== src/itt_ctrl.sv =====
// ----------------------------------------------------------------------------
// itt_ctrl: request intake and result formation
// Launches the search token into the chain, turns the token leaving the
// last cell into a result and a table update, and holds the result until
// the response channel takes it.
// ----------------------------------------------------------------------------
module itt_ctrl import itt_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	itt_req_if.sink          req,
	itt_rsp_if.source        rsp,
	output tok_t             inj_o,
	output wr_t              wr_o,
	output logic [IDX_W-1:0] wr_idx_o,
	input  tok_t             tok_i,
	input  logic [IDX_W-1:0] hit_idx_i,
	input  logic [IDX_W-1:0] free_idx_i
);

	logic                 busy_q;
	tok_t                 inj_q;
	wr_t                  wr_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic                 pend_valid_q;
	logic [STATUS_W-1:0]  pend_status_q;
	logic [VID_OUT_W-1:0] pend_vid_q;
	logic [REAL_W-1:0]    pend_real_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [VID_OUT_W-1:0] out_vid_q;
	logic [REAL_W-1:0]    out_real_q;

	logic                 accept;
	logic                 move;
	logic [STATUS_W-1:0]  fin_status;
	logic [VID_OUT_W-1:0] fin_vid;
	logic [REAL_W-1:0]    fin_real;
	logic                 fin_set;
	logic                 fin_clr;
	logic [IDX_W-1:0]     fin_idx;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign move      = pend_valid_q && (!out_valid_q || rsp.ready);

	// decide the result of the token leaving the chain
	always_comb begin
		fin_status = ST_NOT_FOUND;
		fin_vid    = '0;
		fin_real   = '0;
		fin_set    = 1'b0;
		fin_clr    = 1'b0;
		fin_idx    = free_idx_i;
		case (tok_i.opcode)
			OP_ADD: begin
				if (tok_i.hit) begin
					fin_status = ST_OK;
					fin_vid    = VID_OUT_W'(hit_idx_i);
				end else if (tok_i.free_found) begin
					fin_status = ST_OK;
					fin_vid    = VID_OUT_W'(free_idx_i);
					fin_set    = 1'b1;
				end else begin
					fin_status = ST_NO_FREE;
				end
			end
			OP_LOOKUP: begin
				if (tok_i.rd_used) begin
					fin_status = ST_OK;
					fin_real   = tok_i.rd_real;
				end else begin
					fin_real   = NO_REAL;
				end
			end
			OP_REMOVE: begin
				if (tok_i.rd_used) begin
					fin_status = ST_OK;
					fin_clr    = 1'b1;
					fin_idx    = IDX_W'(tok_i.virtual_id);
				end
			end
			default: begin
				fin_status = ST_NOT_FOUND;
			end
		endcase
	end

	// control: busy, launch, update, pending and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			inj_q        <= '0;
			wr_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				inj_q  <= '{valid: 1'b1, opcode: req.opcode, real_id: req.real_id,
					virtual_id: req.virtual_id, hit: 1'b0, free_found: 1'b0,
					rd_used: 1'b0, rd_real: '0};
			end else begin
				inj_q <= '0;
				if (move) begin
					busy_q <= 1'b0;
				end
			end

			wr_q.set     <= tok_i.valid && fin_set;
			wr_q.clr     <= tok_i.valid && fin_clr;
			wr_q.real_id <= tok_i.real_id;

			if (tok_i.valid) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		wr_idx_q <= fin_idx;
		if (tok_i.valid) begin
			pend_status_q <= fin_status;
			pend_vid_q    <= fin_vid;
			pend_real_q   <= fin_real;
		end
		if (move) begin
			out_status_q <= pend_status_q;
			out_vid_q    <= pend_vid_q;
			out_real_q   <= pend_real_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.virtual_id_out = out_vid_q;
	assign rsp.real_id_out    = out_real_q;

	assign inj_o    = inj_q;
	assign wr_o     = wr_q;
	assign wr_idx_o = wr_idx_q;

endmodule

// ===== src/id_translation_table_allocator_top.sv =====
// ----------------------------------------------------------------------------
// id_translation_table_allocator_top: real-to-virtual ID translation table
// Lowest-free virtual ID allocator with lookup and remove.
// ----------------------------------------------------------------------------
// The table holds MAP_WORDS*WORD_BITS entries, one per cell in a chain.
// Every request (add, lookup, remove) sends a token through the whole chain,
// one cell per cycle; the token leaving the last cell gives a result that is
// registered as pending and then moved to the output register. One request
// is in flight at a time; the next is accepted once the result has moved to
// the output register, even if that result is still waiting to be taken.
// The used bits clear at reset, so the table is usable as soon as reset is
// released.
module id_translation_table_allocator_top import itt_pkg::*; #(
	parameter int MAP_WORDS = 2,
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	itt_req_if.sink   req,
	itt_rsp_if.source rsp
);

	localparam int ID_COUNT = MAP_WORDS * WORD_BITS;
	localparam int IDX_W    = $clog2(ID_COUNT);

	tok_t             tok_c      [ID_COUNT+1];
	logic [IDX_W-1:0] hit_idx_c  [ID_COUNT+1];
	logic [IDX_W-1:0] free_idx_c [ID_COUNT+1];
	wr_t              wr;
	logic [IDX_W-1:0] wr_idx;

	assign hit_idx_c[0]  = '0;
	assign free_idx_c[0] = '0;

	// controller
	itt_ctrl #(
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.inj_o      (tok_c[0]),
		.wr_o       (wr),
		.wr_idx_o   (wr_idx),
		.tok_i      (tok_c[ID_COUNT]),
		.hit_idx_i  (hit_idx_c[ID_COUNT]),
		.free_idx_i (free_idx_c[ID_COUNT])
	);

	// chain of table entries
	for (genvar k = 0; k < ID_COUNT; k++) begin : g_cell
		itt_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_i      (tok_c[k]),
			.hit_idx_i  (hit_idx_c[k]),
			.free_idx_i (free_idx_c[k]),
			.wr_i       (wr),
			.wr_idx_i   (wr_idx),
			.tok_o      (tok_c[k+1]),
			.hit_idx_o  (hit_idx_c[k+1]),
			.free_idx_o (free_idx_c[k+1])
		);
	end

endmodule

// ===== src/itt_checker.sv =====
// ----------------------------------------------------------------------------
// itt_checker: port-level checks of the translation table
// Watches the request and response channels and flags back-to-back accepts,
// result items breaking the block's rules and a changed stalled result.
// ----------------------------------------------------------------------------
module itt_checker import itt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STATUS_W-1:0]  status,
	input logic [VID_OUT_W-1:0] virtual_id_out,
	input logic [REAL_W-1:0]    real_id_out
);

	// one request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)
			&& $stable(virtual_id_out) && $stable(real_id_out)))
		else $error("stalled result changed");

	// a not-found result carries no virtual id and no partial real id
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NOT_FOUND)) |->
			((virtual_id_out == '0) && ((real_id_out == '0) || (real_id_out == NO_REAL))))
		else $error("bad not-found result");

	// exhausted table reports all-zero ids
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NO_FREE)) |->
			((virtual_id_out == '0) && (real_id_out == '0)))
		else $error("bad exhausted result");

endmodule

bind id_translation_table_allocator_top itt_checker u_itt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.status         (rsp.status),
	.virtual_id_out (rsp.virtual_id_out),
	.real_id_out    (rsp.real_id_out)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the ID translation table allocator
// Drives add, lookup and remove requests, and the unused opcode, through the
// request channel. A scoreboard keeps its own copy of the used bits and the
// real id table, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import itt_pkg::*;

	localparam int MAP_WORDS = 2;
	localparam int WORD_BITS = 32;
	localparam int ENTRIES   = MAP_WORDS * WORD_BITS;
	localparam int SLOT_W    = $clog2(ENTRIES);
	localparam int RAND_OPS  = 1200;
	localparam int DRAIN_CYC = 100;
	localparam int LIMIT_CYC = 800000;

	// one request item
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [REAL_W-1:0]   real_id;
		logic [VID_W-1:0]    virtual_id;
	} itt_op_t;

	// one response item
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [VID_OUT_W-1:0] vid;
		logic [REAL_W-1:0]    rid;
	} itt_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// reset, asserted once
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	itt_req_if req_ch ();
	itt_rsp_if rsp_ch ();

	id_translation_table_allocator_top #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// bench-owned drive registers, known from time zero
	logic                req_valid_q = 1'b0;
	logic [OPCODE_W-1:0] req_op_q    = '0;
	logic [REAL_W-1:0]   req_real_q  = '0;
	logic [VID_W-1:0]    req_vid_q   = '0;
	logic                rsp_ready_q = 1'b0;

	assign req_ch.valid      = req_valid_q;
	assign req_ch.opcode     = req_op_q;
	assign req_ch.real_id    = req_real_q;
	assign req_ch.virtual_id = req_vid_q;
	assign rsp_ch.ready      = rsp_ready_q;

	itt_op_t     pending_ops[$];
	itt_result_t expected_results[$];

	// scoreboard copy of the table
	logic              map_used [ENTRIES];
	logic [REAL_W-1:0] map_real [ENTRIES];

	int op_count [4];
	int accepted_count = 0;
	int checked_count  = 0;
	int error_count    = 0;
	int remap_count    = 0;
	int exhaust_count  = 0;
	int stall_left     = 0;
	bit stall_done     = 1'b0;

	int sender_idle_pct;
	int receiver_idle_pct;

	itt_op_t     drv_op;
	itt_result_t got_result;
	itt_result_t exp_result;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			map_used[i] = 1'b0;
			map_real[i] = '0;
		end
		for (int i = 0; i < 4; i++)
			op_count[i] = 0;
	end

	// idling schedule: sender light / receiver heavy, then swapped, then none
	always_comb begin
		if (accepted_count < RAND_OPS / 3) begin
			sender_idle_pct   = 16;
			receiver_idle_pct = 50;
		end else if (accepted_count < 2 * RAND_OPS / 3) begin
			sender_idle_pct   = 50;
			receiver_idle_pct = 16;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
	end

	// predict the response of one accepted request and update the table copy
	function automatic itt_result_t table_apply(input itt_op_t op);
		itt_result_t r;
		int          slot;
		logic        in_range;
		r        = '{status: ST_OK, vid: '0, rid: '0};
		slot     = -1;
		in_range = (op.virtual_id < ENTRIES);
		op_count[op.opcode]++;
		case (op.opcode)
			OP_ADD: begin
				// existing mapping wins over a new claim
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && map_used[i] && map_real[i] == op.real_id)
						slot = i;
				if (slot >= 0) begin
					remap_count++;
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !map_used[i])
							slot = i;
					if (slot >= 0) begin
						map_used[slot] = 1'b1;
						map_real[slot] = op.real_id;
					end
				end
				if (slot >= 0) begin
					r.vid = slot[VID_OUT_W-1:0];
				end else begin
					r.status = ST_NO_FREE;
					exhaust_count++;
				end
			end
			OP_LOOKUP: begin
				if (in_range && map_used[op.virtual_id[SLOT_W-1:0]]) begin
					r.rid = map_real[op.virtual_id[SLOT_W-1:0]];
				end else begin
					r.status = ST_NOT_FOUND;
					r.rid    = NO_REAL;
				end
			end
			OP_REMOVE: begin
				if (in_range && map_used[op.virtual_id[SLOT_W-1:0]])
					map_used[op.virtual_id[SLOT_W-1:0]] = 1'b0;
				else
					r.status = ST_NOT_FOUND;
			end
			default: begin
				r.status = ST_NOT_FOUND;
			end
		endcase
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			req_op_q    <= '0;
			req_real_q  <= '0;
			req_vid_q   <= '0;
		end else begin
			if (req_valid_q && req_ch.ready) begin
				expected_results.push_back(table_apply('{req_op_q, req_real_q, req_vid_q}));
				accepted_count <= accepted_count + 1;
			end
			if (!req_valid_q || req_ch.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					drv_op = pending_ops.pop_front();
					req_valid_q <= 1'b1;
					req_op_q    <= drv_op.opcode;
					req_real_q  <= drv_op.real_id;
					req_vid_q   <= drv_op.virtual_id;
				end else begin
					req_valid_q <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once, while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (!stall_done && accepted_count == 120) begin
			stall_left <= 500;
			stall_done <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready_q <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ready_q) begin
				got_result = '{rsp_ch.status, rsp_ch.virtual_id_out, rsp_ch.real_id_out};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected response status %0d vid %0d real %h",
						$time, got_result.status, got_result.vid, got_result.rid);
					error_count++;
				end else begin
					exp_result = expected_results.pop_front();
					checked_count++;
					if (got_result.status !== exp_result.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_result.status, got_result.status);
						error_count++;
					end
					if (got_result.vid !== exp_result.vid) begin
						$display("%0t: virtual_id_out expected %0d actual %0d",
							$time, exp_result.vid, got_result.vid);
						error_count++;
					end
					if (got_result.rid !== exp_result.rid) begin
						$display("%0t: real_id_out expected %h actual %h",
							$time, exp_result.rid, got_result.rid);
						error_count++;
					end
				end
			end
			if (stall_left != 0)
				rsp_ready_q <= 1'b0;
			else
				rsp_ready_q <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	function automatic void queue_op(input logic [OPCODE_W-1:0] op,
		input logic [REAL_W-1:0] rid, input logic [VID_W-1:0] vid);
		pending_ops.push_back('{op, rid, vid});
	endfunction

	// mostly valid slots, sometimes any 16-bit value
	function automatic logic [VID_W-1:0] pick_vid();
		if ($urandom_range(0, 99) < 85)
			return VID_W'($urandom_range(0, ENTRIES - 1));
		return VID_W'($urandom());
	endfunction

	// small pool repeats real ids so adds hit existing mappings
	function automatic logic [REAL_W-1:0] pick_real();
		if ($urandom_range(0, 99) < 25)
			return REAL_W'($urandom_range(0, 15));
		return REAL_W'($urandom());
	endfunction

	// stimulus and end of run
	initial begin
		int kind;
		int n;
		int r;
		int base;

		// directed: empty table, both real id extremes, remap, range edges
		queue_op(OP_LOOKUP, 16'h0000, 16'd0);
		queue_op(OP_REMOVE, 16'h0000, 16'd0);
		queue_op(OP_ADD,    16'h0000, 16'd0);
		queue_op(OP_ADD,    16'hFFFF, 16'd0);
		queue_op(OP_ADD,    16'h0000, 16'hFFFF);
		queue_op(OP_LOOKUP, 16'h0000, 16'd0);
		queue_op(OP_LOOKUP, 16'h0000, 16'd1);
		queue_op(OP_LOOKUP, 16'h0000, 16'(ENTRIES));
		queue_op(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
		queue_op(OP_REMOVE, 16'h0000, 16'hFFFF);
		queue_op(OP_REMOVE, 16'h0000, 16'(ENTRIES - 1));
		queue_op(2'd3,      16'hFFFF, 16'hFFFF);
		queue_op(2'd3,      16'h0000, 16'h0000);
		queue_op(OP_REMOVE, 16'h0000, 16'd0);
		queue_op(OP_LOOKUP, 16'h0000, 16'd0);
		// lowest free slot is reused
		queue_op(OP_ADD,    16'hA5A5, 16'd0);
		queue_op(OP_ADD,    16'h5A5A, 16'd0);
		queue_op(OP_REMOVE, 16'h0000, 16'd1);
		queue_op(OP_ADD,    16'hFFFF, 16'd0);
		queue_op(OP_REMOVE, 16'h0000, 16'd0);
		queue_op(OP_REMOVE, 16'h0000, 16'd1);
		queue_op(OP_REMOVE, 16'h0000, 16'd2);

		// random phases: fill to exhaustion, churn, drain
		base = pending_ops.size();
		kind = 0;
		while (pending_ops.size() - base < RAND_OPS) begin
			if (kind <= 2) begin
				n = $urandom_range(50, 80);
				for (int i = 0; i < n; i++)
					queue_op(OP_ADD, pick_real(), VID_W'($urandom()));
			end else if (kind <= 7) begin
				for (int i = 0; i < 40; i++) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						queue_op(OP_ADD, pick_real(), VID_W'($urandom()));
					else if (r < 65)
						queue_op(OP_LOOKUP, REAL_W'($urandom()), pick_vid());
					else if (r < 96)
						queue_op(OP_REMOVE, REAL_W'($urandom()), pick_vid());
					else
						queue_op(2'd3, REAL_W'($urandom()), VID_W'($urandom()));
				end
			end else begin
				n = $urandom_range(0, ENTRIES - 1);
				for (int i = 0; i < ENTRIES; i++) begin
					queue_op(OP_REMOVE, REAL_W'($urandom()), VID_W'((n + i) % ENTRIES));
					if ($urandom_range(0, 99) < 15)
						queue_op(OP_LOOKUP, REAL_W'($urandom()), pick_vid());
				end
			end
			kind = $urandom_range(0, 9);
		end

		while (pending_ops.size() != 0 || req_valid_q)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d adds, %0d lookups, %0d removes, %0d unused-opcode items",
			op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("%0d responses checked, %0d adds hit a mapping, %0d found the table full",
			checked_count, remap_count, exhaust_count);
		if (error_count == 0)
			$display("id_translation_table_allocator_top regression: pass");
		else
			$display("id_translation_table_allocator_top regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#(8 * LIMIT_CYC);
		$display("timeout after %0d cycles", LIMIT_CYC);
		$display("id_translation_table_allocator_top regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/itt_pkg.sv
src/itt_req_if.sv
src/itt_rsp_if.sv
src/itt_cell.sv
src/itt_ctrl.sv
src/id_translation_table_allocator_top.sv
src/itt_checker.sv
dv/tb_top.sv
